>>> hw/rtl/longest_decreasing_run_length_macros.svh
// Assertion macros shared by the longest decreasing run length RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef LONGEST_DECREASING_RUN_LENGTH_MACROS_SVH
`define LONGEST_DECREASING_RUN_LENGTH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LDR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LDR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ldr_pkg.sv
// Package for the longest decreasing run length block: widths, types and defaults.
// Depends on nothing; used by the interfaces and all modules.
package ldr_pkg;

  localparam int VALUE_W     = 32;
  localparam int RUN_LEN_W   = 11;
  localparam int MAX_LEN_DEF = 1024;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [RUN_LEN_W-1:0]      run_len_t;

endpackage

>>> hw/rtl/ldr_if.sv
// Request and response channel interfaces of the longest decreasing run length block.
// Depends on ldr_pkg.
interface ldr_req_if;
  logic            valid;
  logic            ready;
  ldr_pkg::value_t value;
  logic            last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface ldr_rsp_if;
  logic              valid;
  logic              ready;
  ldr_pkg::run_len_t run_length;
  logic              overflow;

  modport source (output valid, output run_length, output overflow, input ready);
  modport sink   (input valid, input run_length, input overflow, output ready);
endinterface

>>> hw/rtl/longest_decreasing_run_length.sv
// Longest strictly decreasing subsequence length over a stream of signed 32-bit values.
// Each request passes an accept state, a binary search of at most ceil(log2(L + 1)) tail
// reads, L being the length before it, on the single port of the tail RAM with the compare
// folded into the next read, a search-exit step and a write-back step, which waits until
// the output register is free. A response waits in an output register while the next
// request is searched. last_item clears the length after its response; no clearing pass.
// Depends on ldr_pkg, ldr_if, ldr_tail_mem and ldr_ctrl.
module longest_decreasing_run_length #(
  parameter int MAX_LEN = ldr_pkg::MAX_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ldr_req_if.sink   req_i,
  ldr_rsp_if.source rsp_o
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);

  logic            mem_en;
  logic            mem_we;
  logic [AW-1:0]   mem_addr;
  ldr_pkg::value_t mem_wdata;
  ldr_pkg::value_t mem_rdata;

  ldr_ctrl #(
    .MAX_LEN (MAX_LEN),
    .AW      (AW),
    .LW      (LW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_en_o    (mem_en),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  ldr_tail_mem #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_tail_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

>>> hw/rtl/ldr_tail_mem.sv
// Tail store of the longest decreasing run length block: single-port synchronous RAM.
// Depends on ldr_pkg for the entry type.
module ldr_tail_mem #(
  parameter int DEPTH = ldr_pkg::MAX_LEN_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic            we_i,
  input  logic [AW-1:0]   addr_i,
  input  ldr_pkg::value_t wdata_i,
  output ldr_pkg::value_t rdata_o
);

  ldr_pkg::value_t mem_q [DEPTH];
  ldr_pkg::value_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ldr_ctrl.sv
// Search and update sequencer of the longest decreasing run length block.
// Depends on ldr_pkg, ldr_if and the assertion macros; drives ldr_tail_mem.
`include "longest_decreasing_run_length_macros.svh"

module ldr_ctrl #(
  parameter int MAX_LEN = ldr_pkg::MAX_LEN_DEF,
  parameter int AW      = $clog2(MAX_LEN),
  parameter int LW      = $clog2(MAX_LEN + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ldr_req_if.sink           req_i,
  ldr_rsp_if.source         rsp_o,
  output logic              mem_en_o,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_addr_o,
  output ldr_pkg::value_t   mem_wdata_o,
  input  ldr_pkg::value_t   mem_rdata_i
);

  localparam int RLW = ldr_pkg::RUN_LEN_W;
  localparam logic [LW-1:0] MaxLenL = LW'(MAX_LEN);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SRCH = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  state_e          state_q, state_d;
  ldr_pkg::value_t key_q, key_d;
  logic            last_q, last_d;
  logic [LW-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic            pend_q, pend_d;
  logic [LW-1:0]   len_q, len_d;
  logic [LW-1:0]   res_len_q, res_len_d;
  logic            res_ovf_q, res_ovf_d;
  logic            out_valid_q, out_valid_d;

  logic [LW-1:0]   lo_n, hi_n, mid_n;
  logic            append, full;

  always_comb begin
    // Fold in the compare of the tail read in the previous cycle.
    lo_n = lo_q;
    hi_n = hi_q;
    if (pend_q) begin
      if (mem_rdata_i > key_q) begin
        lo_n = mid_q + LW'(1);
      end else begin
        hi_n = mid_q;
      end
    end
    mid_n  = lo_n + ((hi_n - lo_n) >> 1);
    append = (lo_q == len_q);
    full   = (len_q == MaxLenL);
  end

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    last_d      = last_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    pend_d      = 1'b0;
    len_d       = len_q;
    res_len_d   = res_len_q;
    res_ovf_d   = res_ovf_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    mem_en_o    = 1'b0;
    mem_we_o    = 1'b0;
    mem_addr_o  = mid_n[AW-1:0];
    mem_wdata_o = key_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          key_d   = req_i.value;
          last_d  = req_i.last_item;
          lo_d    = '0;
          hi_d    = len_q;
          state_d = ST_SRCH;
        end
      end
      ST_SRCH: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mem_en_o = 1'b1;
          mid_d    = mid_n;
          pend_d   = 1'b1;
        end else begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        // Hold the update until the result register can take the response.
        if (!out_valid_q || rsp_o.ready) begin
          mem_addr_o = lo_q[AW-1:0];
          res_ovf_d  = 1'b0;
          res_len_d  = len_q;
          if (!append) begin
            mem_en_o = 1'b1;
            mem_we_o = 1'b1;
          end else if (!full) begin
            mem_en_o  = 1'b1;
            mem_we_o  = 1'b1;
            res_len_d = len_q + LW'(1);
          end else begin
            res_ovf_d = 1'b1;
          end
          len_d       = last_q ? '0 : res_len_d;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    last_q    <= last_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    res_len_q <= res_len_d;
    res_ovf_q <= res_ovf_d;
  end

  assign req_i.ready      = (state_q == ST_IDLE);
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.run_length = RLW'(res_len_q);
  assign rsp_o.overflow   = res_ovf_q;

  `LDR_ASSERT_NOW(a_len_bound, clk_i, rst_ni, 1'b1, len_q <= MaxLenL, "length above capacity")
  `LDR_ASSERT_NOW(a_window_order, clk_i, rst_ni, state_q == ST_SRCH,
                  (lo_q <= hi_q) && (hi_q <= len_q), "search window out of range")
  `LDR_ASSERT_NOW(a_ovf_full, clk_i, rst_ni, out_valid_q && res_ovf_q,
                  res_len_q == MaxLenL, "overflow reported below capacity")
  `LDR_ASSERT_NEXT(a_req_starts_search, clk_i, rst_ni, req_i.valid && req_i.ready,
                   (state_q == ST_SRCH) && !pend_q, "accepted request did not start a search")

endmodule

>>> sim/tb_top.sv
// Testbench for longest_decreasing_run_length: random and directed signed value streams,
// checked against a patience-tail model of the longest strictly decreasing run.
// Depends on ldr_pkg, ldr_if and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  typedef ldr_pkg::value_t   value_t;
  typedef ldr_pkg::run_len_t run_len_t;

  localparam int     MAX_LEN     = ldr_pkg::MAX_LEN_DEF;
  localparam int     ITEM_TARGET = 1550;
  localparam value_t VAL_MIN     = value_t'(32'h8000_0000);
  localparam value_t VAL_MAX     = value_t'(32'h7FFF_FFFF);

  typedef struct {
    value_t      value;
    logic        last_item;
    int unsigned gap;
    bit          drain;
  } seq_req_t;

  typedef struct {
    run_len_t run_length;
    logic     overflow;
  } run_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ldr_req_if req_if ();
  ldr_rsp_if rsp_if ();

  longest_decreasing_run_length #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Model state: strictly descending tails, one per reachable run length.
  value_t      tails [MAX_LEN];
  int unsigned tail_count;

  seq_req_t    req_pending [$];
  run_rsp_t    expected_rsp [$];
  int unsigned idle_waited;
  int unsigned stall_left;
  bit          steady_sender;
  int unsigned req_queued;
  int unsigned req_sent;
  int unsigned rsp_seen;
  int unsigned ovf_seen;
  int unsigned peak_length;
  int unsigned errors;

  function automatic run_rsp_t predict_run_length(value_t v, logic last);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    run_rsp_t    r;
    lo = 0;
    hi = tail_count;
    // First tail that is not greater than the new value.
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tails[mid] > v) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    r.overflow = 1'b0;
    if (lo == tail_count) begin
      if (tail_count < MAX_LEN) begin
        tails[lo] = v;
        tail_count++;
      end else begin
        r.overflow = 1'b1;
      end
    end else begin
      tails[lo] = v;
    end
    r.run_length = run_len_t'(tail_count);
    if (last) begin
      tail_count = 0;
    end
    return r;
  endfunction

  task automatic add_req(value_t v, logic last, bit drain);
    seq_req_t s;
    s.value     = v;
    s.last_item = last;
    s.gap       = steady_sender ? 0 : $urandom_range(0, 3);
    s.drain     = drain;
    req_pending.push_back(s);
    req_queued++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_req
    logic slot_free;
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.value     <= '0;
      req_if.last_item <= 1'b0;
      idle_waited      <= 0;
    end else begin
      slot_free = !req_if.valid || req_if.ready;
      if (req_if.valid && req_if.ready) begin
        expected_rsp.push_back(predict_run_length(req_if.value, req_if.last_item));
        req_sent++;
      end
      if (slot_free) begin
        if (req_pending.size() == 0) begin
          req_if.valid <= 1'b0;
        end else if (idle_waited < req_pending[0].gap) begin
          idle_waited  <= idle_waited + 1;
          req_if.valid <= 1'b0;
        end else if (req_pending[0].drain && expected_rsp.size() != 0) begin
          // Hold off until the block has answered everything in flight.
          req_if.valid <= 1'b0;
        end else begin
          req_if.valid     <= 1'b1;
          req_if.value     <= req_pending[0].value;
          req_if.last_item <= req_pending[0].last_item;
          idle_waited      <= 0;
          void'(req_pending.pop_front());
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch_rsp
    run_rsp_t    want;
    int unsigned stall;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_seen++;
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected response, expected none, got length %0d overflow %0b",
                   $time, rsp_if.run_length, rsp_if.overflow);
          errors++;
        end else begin
          want = expected_rsp.pop_front();
          if (want.overflow) begin
            ovf_seen++;
          end
          if (want.run_length > peak_length) begin
            peak_length = want.run_length;
          end
          if (rsp_if.run_length !== want.run_length) begin
            $display("%0t: run_length mismatch, expected %0d, got %0d",
                     $time, want.run_length, rsp_if.run_length);
            errors++;
          end
          if (rsp_if.overflow !== want.overflow) begin
            $display("%0t: overflow mismatch, expected %0b, got %0b",
                     $time, want.overflow, rsp_if.overflow);
            errors++;
          end
        end
        // Every fourth stretch of 128 responses is taken without stalling.
        stall = ((rsp_seen / 128) % 4 == 3) ? 0 : $urandom_range(0, 3);
        rsp_if.ready <= (stall == 0);
        stall_left   <= stall;
      end else if (stall_left > 1) begin
        stall_left   <= stall_left - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        stall_left   <= 0;
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    value_t      walk;
    value_t      v;
    int unsigned kind;
    int unsigned seq_len;
    int unsigned seq_idx;
    logic        last;

    req_if.valid     = 1'b0;
    req_if.value     = '0;
    req_if.last_item = 1'b0;
    rsp_if.ready     = 1'b0;
    rst_ni           = 1'b0;
    tail_count       = 0;
    req_queued       = 0;
    req_sent         = 0;
    rsp_seen         = 0;
    ovf_seen         = 0;
    peak_length      = 0;
    errors           = 0;
    steady_sender    = 1'b0;

    // Directed: equal values replace, extremes append and replace, sequence ends.
    add_req(value_t'(0), 1'b0, 1'b0);
    add_req(value_t'(0), 1'b0, 1'b0);
    add_req(value_t'(-1), 1'b0, 1'b0);
    add_req(VAL_MAX, 1'b0, 1'b0);
    add_req(VAL_MIN, 1'b0, 1'b0);
    add_req(VAL_MIN, 1'b0, 1'b0);
    add_req(value_t'(-5), 1'b1, 1'b0);
    add_req(VAL_MIN, 1'b1, 1'b0);
    add_req(VAL_MAX, 1'b0, 1'b0);
    add_req(value_t'(32'h5555_5555), 1'b0, 1'b0);
    add_req(value_t'(1), 1'b0, 1'b0);
    add_req(value_t'(0), 1'b0, 1'b0);
    add_req(value_t'(-1), 1'b0, 1'b0);
    add_req(value_t'(32'hAAAA_AAAA), 1'b0, 1'b0);
    add_req(VAL_MIN, 1'b1, 1'b0);
    add_req(value_t'(1), 1'b0, 1'b0);
    add_req(value_t'(2), 1'b0, 1'b0);
    add_req(value_t'(3), 1'b1, 1'b0);

    // One sequence that fills the whole tail store, then needs appends past it.
    walk = VAL_MAX;
    for (int i = 0; i < MAX_LEN; i++) begin
      add_req(walk, 1'b0, i == 0);
      walk = walk - value_t'($urandom_range(1, 1 << 20));
    end
    add_req(walk, 1'b0, 1'b0);
    add_req(VAL_MAX, 1'b0, 1'b0);
    add_req(value_t'(0), 1'b0, 1'b0);
    add_req(walk, 1'b0, 1'b0);
    add_req(VAL_MIN, 1'b1, 1'b0);

    seq_idx = 0;
    while (req_queued < ITEM_TARGET) begin
      steady_sender = (seq_idx % 7 == 3);
      kind    = $urandom_range(0, 9);
      seq_len = $urandom_range(1, 48);
      walk    = value_t'($urandom);
      for (int i = 0; i < seq_len; i++) begin
        last = (i == seq_len - 1);
        case (kind)
          0, 1, 2: v = value_t'($urandom);
          3, 4:    v = value_t'(int'($urandom_range(0, 16)) - 8);
          5, 6, 7: begin
            // Mostly falling walk, so runs grow long.
            if ($urandom_range(0, 5) == 0) begin
              walk = walk + value_t'($urandom_range(0, 100));
            end else begin
              walk = walk - value_t'($urandom_range(0, 40));
            end
            v = walk;
          end
          8: begin
            case ($urandom_range(0, 5))
              0:       v = VAL_MIN;
              1:       v = VAL_MAX;
              2:       v = value_t'(0);
              3:       v = value_t'(-1);
              4:       v = value_t'(1);
              default: v = value_t'($urandom);
            endcase
          end
          default: begin
            // Noise: sequence boundaries fall anywhere, or not at all.
            v    = value_t'($urandom);
            last = ($urandom_range(0, 7) == 0);
          end
        endcase
        add_req(v, last, (i == 0) && (seq_idx % 25 == 0));
      end
      seq_idx++;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (req_pending.size() != 0 || req_if.valid || expected_rsp.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);

    $display("Sent %0d requests over %0d random sequences plus directed and full-store runs.",
             req_sent, seq_idx);
    $display("Checked %0d responses, %0d with overflow, longest run %0d.",
             rsp_seen, ovf_seen, peak_length);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/ldr_pkg.sv
hw/rtl/ldr_if.sv
hw/rtl/ldr_tail_mem.sv
hw/rtl/ldr_ctrl.sv
hw/rtl/longest_decreasing_run_length.sv
sim/tb_top.sv
